### rtl/core/spg_pkg.sv
// shared types, constants and helpers of the sigma point generator
`timescale 1ns / 1ps

package spg_pkg;

    localparam int SIDE          = 8;
    localparam int IDX_W         = 3;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int DEN_W         = 34;
    localparam int REM_W         = 35;
    localparam int DIM_W         = 4;
    localparam int PT_W          = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    localparam logic signed [WIDE_W-1:0] ACC_LIMIT = 64'sh2000_0000_0000_0000;
    localparam logic signed [WIDE_W:0]   SAT_HI    = 65'sd2147483647;
    localparam logic signed [WIDE_W:0]   SAT_LO    = -65'sd2147483648;
    localparam logic signed [DATA_W-1:0] MAX32     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN32     = 32'sh8000_0000;

    typedef enum logic [1:0] {
        FUNC_MEAN = 2'd0,
        FUNC_COV  = 2'd1,
        FUNC_RUN  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM   = 1'b0,
        CFG_KAPPA = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W0,
        ST_WI,
        ST_ROOT,
        ST_CHOL_RD,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_DIFF,
        ST_UNIT_WAIT,
        ST_PT_START,
        ST_PT_RD,
        ST_PT_MUL,
        ST_PT_SUM,
        ST_PUSH,
        ST_BAD
    } seq_state_t;

    typedef struct packed {
        logic                      start;
        unit_op_t                  op;
        logic signed [WIDE_W-1:0]  num;
        logic [DEN_W-1:0]          den;
    } unit_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0]  value;
    } unit_rsp_t;

    typedef struct packed {
        logic [PT_W-1:0]                point_index;
        logic signed [DATA_W-1:0]       point_weight;
        logic [SIDE-1:0][DATA_W-1:0]    coords;
        logic                           last_point;
        logic                           bad_input;
    } point_t;

    // clamp a wide signed value into 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = MAX32;
        end else if (v < SAT_LO) begin
            r = MIN32;
        end else begin
            r = signed'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

### rtl/core/spg_unit.sv
// shared iterative unit: signed divide by a positive divisor, integer square root
`timescale 1ns / 1ps

module spg_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  spg_pkg::unit_req_t req,
    output spg_pkg::unit_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [6:0]                        cnt_reg;
    spg_pkg::unit_op_t                 op_reg;
    logic                              neg_reg;
    logic [spg_pkg::WIDE_W-1:0]        num_reg;
    logic [spg_pkg::WIDE_W-1:0]        q_reg;
    logic [spg_pkg::REM_W-1:0]         rem_reg;
    logic [spg_pkg::DEN_W-1:0]         den_reg;

    logic [6:0]                        last_cnt;
    logic [spg_pkg::REM_W-1:0]         rem_sh;
    logic [spg_pkg::REM_W-1:0]         trial;
    logic [spg_pkg::REM_W-1:0]         rem_next;
    logic [spg_pkg::WIDE_W-1:0]        q_next;
    logic [spg_pkg::WIDE_W-1:0]        num_next;
    logic                              qbit;
    logic signed [spg_pkg::DATA_W-1:0] value;

    assign last_cnt = (op_reg == spg_pkg::OP_DIV) ? 7'd63 : 7'd31;

    // one quotient bit or one root bit per cycle
    always_comb
    begin
        if (op_reg == spg_pkg::OP_DIV) begin
            rem_sh   = {rem_reg[spg_pkg::REM_W-2:0], num_reg[spg_pkg::WIDE_W-1]};
            trial    = {1'b0, den_reg};
            num_next = {num_reg[spg_pkg::WIDE_W-2:0], 1'b0};
        end else begin
            rem_sh   = {rem_reg[spg_pkg::REM_W-3:0], num_reg[spg_pkg::WIDE_W-1 -: 2]};
            trial    = {1'b0, q_reg[31:0], 2'b01};
            num_next = {num_reg[spg_pkg::WIDE_W-3:0], 2'b00};
        end
        qbit     = (rem_sh >= trial);
        rem_next = qbit ? (rem_sh - trial) : rem_sh;
        q_next   = {q_reg[spg_pkg::WIDE_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == last_cnt);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == last_cnt) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            op_reg  <= req.op;
            den_reg <= req.den;
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= (req.op == spg_pkg::OP_DIV) && req.num[spg_pkg::WIDE_W-1];
            if ((req.op == spg_pkg::OP_DIV) && req.num[spg_pkg::WIDE_W-1]) begin
                num_reg <= unsigned'(-req.num);
            end else begin
                num_reg <= unsigned'(req.num);
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            num_reg <= num_next;
        end
    end

    // truncated quotient or floor root, saturated to 32 bits
    always_comb
    begin
        if (op_reg == spg_pkg::OP_SQRT) begin
            value = q_reg[31] ? spg_pkg::MAX32 : signed'(q_reg[31:0]);
        end else if (!neg_reg) begin
            value = (q_reg > 64'h7FFF_FFFF) ? spg_pkg::MAX32 : signed'(q_reg[31:0]);
        end else begin
            value = (q_reg > 64'h8000_0000) ? spg_pkg::MIN32 : signed'(-q_reg[31:0]);
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value;

endmodule

### rtl/core/spg_seq.sv
// sequencer with the covariance, factor and mean stores
`timescale 1ns / 1ps

module spg_seq
#(
    parameter int MAX_DIM   = spg_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = spg_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_accept,
    input  logic [1:0]                        func,
    input  logic [spg_pkg::IDX_W-1:0]         row_index,
    input  logic [spg_pkg::IDX_W-1:0]         col_index,
    input  logic signed [spg_pkg::DATA_W-1:0] element_value,
    input  logic [spg_pkg::DIM_W-1:0]         state_dimension,
    input  logic signed [spg_pkg::DATA_W-1:0] spread_kappa,
    input  logic                              push_ready,
    output logic                              push_valid,
    output spg_pkg::point_t                   point,
    output logic                              idle,
    output spg_pkg::unit_req_t                unit_req,
    input  spg_pkg::unit_rsp_t                unit_rsp
);

    localparam logic [spg_pkg::DIM_W-1:0]         MAX_N = spg_pkg::DIM_W'(MAX_DIM);
    localparam logic signed [spg_pkg::WIDE_W-1:0] ONE   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [spg_pkg::WIDE_W-1:0] ONE2  = 64'sd1 <<< (2 * FRAC_BITS);

    spg_pkg::seq_state_t state_reg, state_next;

    logic [spg_pkg::DIM_W-1:0]         i_reg, j_reg, k_reg, c_reg;
    logic [spg_pkg::PT_W-1:0]          p_reg;
    logic signed [spg_pkg::WIDE_W-1:0] acc_reg, prod_reg;
    logic signed [spg_pkg::DATA_W-1:0] ljj_reg, w0_reg, wi_reg, root_reg;
    logic signed [spg_pkg::DATA_W-1:0] coord_reg [spg_pkg::SIDE];
    logic signed [spg_pkg::DATA_W-1:0] mean_reg  [spg_pkg::SIDE];

    logic signed [spg_pkg::DATA_W-1:0] cov_mem [spg_pkg::SIDE * spg_pkg::SIDE];
    logic signed [spg_pkg::DATA_W-1:0] low_mem [spg_pkg::SIDE * spg_pkg::SIDE];
    logic signed [spg_pkg::DATA_W-1:0] cov_rd_reg, low_a_reg, low_b_reg;

    logic                              run_go;
    logic [spg_pkg::DIM_W-1:0]         n_eff;
    logic signed [spg_pkg::WIDE_W-1:0] kappa_sx, s_val, d_val;
    logic                              s_pos, diag, d_bad;
    logic [spg_pkg::PT_W-1:0]          p_last, p_m1, col5;
    logic [spg_pkg::DIM_W-1:0]         col_val;
    logic                              minus_pt, pt_last, fac_mask;
    logic signed [spg_pkg::WIDE_W:0]   acc_sum, acc_clamped;
    logic signed [spg_pkg::WIDE_W-1:0] prod_adj;
    logic signed [spg_pkg::DATA_W-1:0] fac, coord_val;
    logic signed [spg_pkg::DATA_W:0]   coord_sum;

    logic                              cov_re, low_re, low_we;
    logic [spg_pkg::ADDR_W-1:0]        cov_raddr, low_aaddr, low_baddr, low_waddr;

    // clamp n into 1..MAX_DIM
    always_comb
    begin
        if (state_dimension == '0) begin
            n_eff = 4'd1;
        end else if (state_dimension > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = state_dimension;
        end
    end

    assign run_go   = in_accept && (func == spg_pkg::FUNC_RUN);
    assign kappa_sx = 64'(spread_kappa);
    assign s_val    = (64'(n_eff) <<< FRAC_BITS) + kappa_sx;
    assign s_pos    = (s_val > 64'sd0);
    assign diag     = (i_reg == j_reg);
    assign d_val    = (64'(cov_rd_reg) <<< FRAC_BITS) - acc_reg;
    assign d_bad    = diag && (d_val <= 64'sd0);

    // point p: column and sign
    assign p_last   = {n_eff, 1'b0};
    assign p_m1     = p_reg - 5'd1;
    assign minus_pt = (p_reg > {1'b0, n_eff});
    assign col5     = minus_pt ? (p_m1 - {1'b0, n_eff}) : p_m1;
    assign col_val  = col5[spg_pkg::DIM_W-1:0];
    assign pt_last  = (p_reg == p_last);
    assign fac_mask = (p_reg == '0) || (c_reg < col_val);

    assign acc_sum     = {acc_reg[spg_pkg::WIDE_W-1], acc_reg}
                         + {prod_reg[spg_pkg::WIDE_W-1], prod_reg};
    assign acc_clamped = (acc_sum > 65'(spg_pkg::ACC_LIMIT)) ? 65'(spg_pkg::ACC_LIMIT)
                       : (acc_sum < -65'(spg_pkg::ACC_LIMIT)) ? -65'(spg_pkg::ACC_LIMIT)
                       : acc_sum;

    // factor entry scaled by the root, truncated toward zero
    assign prod_adj  = prod_reg + (prod_reg[spg_pkg::WIDE_W-1] ? (ONE - 64'sd1) : 64'sd0);
    assign fac       = fac_mask ? '0
                     : spg_pkg::sat32(65'(prod_adj >>> FRAC_BITS));
    assign coord_sum = minus_pt
                     ? (33'(mean_reg[c_reg[spg_pkg::IDX_W-1:0]]) - 33'(fac))
                     : (33'(mean_reg[c_reg[spg_pkg::IDX_W-1:0]]) + 33'(fac));
    assign coord_val = spg_pkg::sat32(65'(coord_sum));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spg_pkg::ST_IDLE:
                if (run_go) state_next = s_pos ? spg_pkg::ST_W0 : spg_pkg::ST_BAD;
            spg_pkg::ST_W0:
                if (unit_rsp.done) state_next = spg_pkg::ST_WI;
            spg_pkg::ST_WI:
                if (unit_rsp.done) state_next = spg_pkg::ST_ROOT;
            spg_pkg::ST_ROOT:
                if (unit_rsp.done) state_next = spg_pkg::ST_CHOL_RD;
            spg_pkg::ST_CHOL_RD:
                state_next = (j_reg == '0) ? spg_pkg::ST_DIFF : spg_pkg::ST_ACC_RD;
            spg_pkg::ST_ACC_RD:
                state_next = spg_pkg::ST_ACC_MUL;
            spg_pkg::ST_ACC_MUL:
                state_next = spg_pkg::ST_ACC_ADD;
            spg_pkg::ST_ACC_ADD:
                state_next = ((k_reg + 4'd1) < j_reg) ? spg_pkg::ST_ACC_RD : spg_pkg::ST_DIFF;
            spg_pkg::ST_DIFF:
                state_next = d_bad ? spg_pkg::ST_BAD : spg_pkg::ST_UNIT_WAIT;
            spg_pkg::ST_UNIT_WAIT:
                if (unit_rsp.done) begin
                    if (((i_reg + 4'd1) < n_eff) || ((j_reg + 4'd1) < n_eff)) begin
                        state_next = spg_pkg::ST_CHOL_RD;
                    end else begin
                        state_next = spg_pkg::ST_PT_START;
                    end
                end
            spg_pkg::ST_PT_START:
                state_next = spg_pkg::ST_PT_RD;
            spg_pkg::ST_PT_RD:
                state_next = spg_pkg::ST_PT_MUL;
            spg_pkg::ST_PT_MUL:
                state_next = spg_pkg::ST_PT_SUM;
            spg_pkg::ST_PT_SUM:
                state_next = ((c_reg + 4'd1) < n_eff) ? spg_pkg::ST_PT_RD : spg_pkg::ST_PUSH;
            spg_pkg::ST_PUSH:
                if (push_ready) state_next = pt_last ? spg_pkg::ST_IDLE : spg_pkg::ST_PT_START;
            spg_pkg::ST_BAD:
                if (push_ready) state_next = spg_pkg::ST_IDLE;
            default:
                state_next = spg_pkg::ST_IDLE;
        endcase
    end

    // outputs: unit requests, store ports, result
    always_comb
    begin
        unit_req   = '0;
        cov_re     = 1'b0;
        low_re     = 1'b0;
        low_we     = 1'b0;
        cov_raddr  = {i_reg[spg_pkg::IDX_W-1:0], j_reg[spg_pkg::IDX_W-1:0]};
        low_aaddr  = {i_reg[spg_pkg::IDX_W-1:0], k_reg[spg_pkg::IDX_W-1:0]};
        low_baddr  = {j_reg[spg_pkg::IDX_W-1:0], k_reg[spg_pkg::IDX_W-1:0]};
        low_waddr  = {i_reg[spg_pkg::IDX_W-1:0], j_reg[spg_pkg::IDX_W-1:0]};
        push_valid = 1'b0;
        point      = '0;
        unique case (state_reg)
            spg_pkg::ST_IDLE:
                if (run_go && s_pos) begin
                    unit_req.start = 1'b1;
                    unit_req.op    = spg_pkg::OP_DIV;
                    unit_req.num   = kappa_sx <<< FRAC_BITS;
                    unit_req.den   = s_val[spg_pkg::DEN_W-1:0];
                end
            spg_pkg::ST_W0:
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    unit_req.op    = spg_pkg::OP_DIV;
                    unit_req.num   = ONE2;
                    unit_req.den   = {s_val[spg_pkg::DEN_W-2:0], 1'b0};
                end
            spg_pkg::ST_WI:
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    unit_req.op    = spg_pkg::OP_SQRT;
                    unit_req.num   = s_val <<< FRAC_BITS;
                end
            spg_pkg::ST_CHOL_RD:
                cov_re = 1'b1;
            spg_pkg::ST_ACC_RD:
                low_re = 1'b1;
            spg_pkg::ST_DIFF:
                if (!d_bad) begin
                    unit_req.start = 1'b1;
                    unit_req.op    = diag ? spg_pkg::OP_SQRT : spg_pkg::OP_DIV;
                    unit_req.num   = d_val;
                    unit_req.den   = {2'b00, unsigned'(ljj_reg)};
                end
            spg_pkg::ST_UNIT_WAIT:
                low_we = unit_rsp.done;
            spg_pkg::ST_PT_RD:
            begin
                low_re    = 1'b1;
                low_aaddr = {c_reg[spg_pkg::IDX_W-1:0], col_val[spg_pkg::IDX_W-1:0]};
            end
            spg_pkg::ST_PUSH:
            begin
                push_valid         = 1'b1;
                point.point_index  = p_reg;
                point.point_weight = (p_reg == '0) ? w0_reg : wi_reg;
                for (int c = 0; c < spg_pkg::SIDE; c++) begin
                    point.coords[c] = coord_reg[c];
                end
                point.last_point   = pt_last;
            end
            spg_pkg::ST_BAD:
            begin
                push_valid       = 1'b1;
                point.last_point = 1'b1;
                point.bad_input  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign idle = (state_reg == spg_pkg::ST_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= spg_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            p_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == spg_pkg::ST_ROOT) && unit_rsp.done) begin
                i_reg <= '0;
                j_reg <= '0;
                p_reg <= '0;
            end
            if (state_reg == spg_pkg::ST_CHOL_RD) begin
                k_reg <= '0;
            end
            if (state_reg == spg_pkg::ST_ACC_ADD) begin
                k_reg <= k_reg + 4'd1;
            end
            if ((state_reg == spg_pkg::ST_UNIT_WAIT) && unit_rsp.done) begin
                if ((i_reg + 4'd1) < n_eff) begin
                    i_reg <= i_reg + 4'd1;
                end else begin
                    j_reg <= j_reg + 4'd1;
                    i_reg <= j_reg + 4'd1;
                end
            end
            if (state_reg == spg_pkg::ST_PT_START) begin
                c_reg <= '0;
            end
            if (state_reg == spg_pkg::ST_PT_SUM) begin
                c_reg <= c_reg + 4'd1;
            end
            if ((state_reg == spg_pkg::ST_PUSH) && push_ready) begin
                p_reg <= p_reg + 5'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept && idle && (func == spg_pkg::FUNC_MEAN)) begin
            mean_reg[row_index] <= element_value;
        end
        if ((state_reg == spg_pkg::ST_W0) && unit_rsp.done) begin
            w0_reg <= unit_rsp.value;
        end
        if ((state_reg == spg_pkg::ST_WI) && unit_rsp.done) begin
            wi_reg <= unit_rsp.value;
        end
        if ((state_reg == spg_pkg::ST_ROOT) && unit_rsp.done) begin
            root_reg <= unit_rsp.value;
        end
        if (state_reg == spg_pkg::ST_CHOL_RD) begin
            acc_reg <= '0;
        end
        if (state_reg == spg_pkg::ST_ACC_MUL) begin
            prod_reg <= 64'(low_a_reg) * 64'(low_b_reg);
        end
        if (state_reg == spg_pkg::ST_ACC_ADD) begin
            acc_reg <= acc_clamped[spg_pkg::WIDE_W-1:0];
        end
        if ((state_reg == spg_pkg::ST_UNIT_WAIT) && unit_rsp.done && diag) begin
            ljj_reg <= unit_rsp.value;
        end
        if (state_reg == spg_pkg::ST_PT_START) begin
            for (int c = 0; c < spg_pkg::SIDE; c++) begin
                coord_reg[c] <= '0;
            end
        end
        if (state_reg == spg_pkg::ST_PT_MUL) begin
            prod_reg <= 64'(low_a_reg) * 64'(root_reg);
        end
        if (state_reg == spg_pkg::ST_PT_SUM) begin
            coord_reg[c_reg[spg_pkg::IDX_W-1:0]] <= coord_val;
        end
    end

    // covariance store
    always_ff @(posedge clk)
    begin
        if (in_accept && idle && (func == spg_pkg::FUNC_COV)) begin
            cov_mem[{row_index, col_index}] <= element_value;
        end
        if (cov_re) begin
            cov_rd_reg <= cov_mem[cov_raddr];
        end
    end

    // lower factor store, two read ports
    always_ff @(posedge clk)
    begin
        if (low_we) begin
            low_mem[low_waddr] <= unit_rsp.value;
        end
        if (low_re) begin
            low_a_reg <= low_mem[low_aaddr];
            low_b_reg <= low_mem[low_baddr];
        end
    end

endmodule

### rtl/core/sigma_point_generator.sv
// top level of the sigma point generator: config registers, output register
//
// input channel (in_valid / in_stall): func 0 writes a mean element, func 1 a
// covariance element (lower triangle is used), func 2 runs the transform, func 3
// is dropped. the block stalls its input while a run is in progress.
// a run produces 2n+1 transactions on the output channel (out_valid / out_stall):
// point 0 is the mean, then mean plus each scaled factor column, then mean minus.
// a bad run (n+kappa not positive or covariance not positive definite) gives a
// single transaction with bad_input and last_point set.
// run sequence: the two weight divides and the root, then each factor entry in
// column j, a root on the diagonal and a divide below it (one shared bit-serial
// divide/root unit), then the coordinates of each point are gathered while the
// receiver keeps up.
// the config port (cfg_valid / cfg_ready, always ready) is to be written only when idle; the block does not enforce it.
// a stalled result sits in the output register; the sequencer waits for it.
// reset clears the control state, sets n to 3 and kappa to 0; the stores are
// undefined until written.
`timescale 1ns / 1ps

module sigma_point_generator
#(
    parameter int MAX_DIM   = spg_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = spg_pkg::FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            func,
    input  logic [spg_pkg::IDX_W-1:0]             row_index,
    input  logic [spg_pkg::IDX_W-1:0]             col_index,
    input  logic signed [spg_pkg::DATA_W-1:0]     element_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [spg_pkg::PT_W-1:0]              point_index,
    output logic signed [spg_pkg::DATA_W-1:0]     point_weight,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_0,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_1,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_2,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_3,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_4,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_5,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_6,
    output logic signed [spg_pkg::DATA_W-1:0]     coord_7,
    output logic                                  last_point,
    output logic                                  bad_input,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spg_pkg::DATA_W-1:0]            cfg_data
);

    logic [spg_pkg::DIM_W-1:0]         dim_reg;
    logic signed [spg_pkg::DATA_W-1:0] kappa_reg;
    logic                              out_valid_reg;
    spg_pkg::point_t                   out_reg;

    logic                              in_accept;
    logic                              seq_idle;
    logic                              push_valid;
    logic                              push_ready;
    spg_pkg::point_t                   push_point;
    spg_pkg::unit_req_t                unit_req;
    spg_pkg::unit_rsp_t                unit_rsp;

    // loads and runs only enter while the sequencer is idle
    assign in_stall  = !seq_idle;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // output register frees up when its transaction is taken
    assign push_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dim_reg   <= spg_pkg::DIM_RESET;
            kappa_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (spg_pkg::cfg_idx_t'(cfg_index))
                spg_pkg::CFG_DIM:   dim_reg   <= cfg_data[spg_pkg::DIM_W-1:0];
                spg_pkg::CFG_KAPPA: kappa_reg <= signed'(cfg_data);
                default:            dim_reg   <= dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (push_ready) begin
            out_valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid) begin
            out_reg <= push_point;
        end
    end

    spg_seq
    #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    )
    u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_accept       (in_accept),
        .func            (func),
        .row_index       (row_index),
        .col_index       (col_index),
        .element_value   (element_value),
        .state_dimension (dim_reg),
        .spread_kappa    (kappa_reg),
        .push_ready      (push_ready),
        .push_valid      (push_valid),
        .point           (push_point),
        .idle            (seq_idle),
        .unit_req        (unit_req),
        .unit_rsp        (unit_rsp)
    );

    spg_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    assign out_valid    = out_valid_reg;
    assign point_index  = out_reg.point_index;
    assign point_weight = out_reg.point_weight;
    assign coord_0      = signed'(out_reg.coords[0]);
    assign coord_1      = signed'(out_reg.coords[1]);
    assign coord_2      = signed'(out_reg.coords[2]);
    assign coord_3      = signed'(out_reg.coords[3]);
    assign coord_4      = signed'(out_reg.coords[4]);
    assign coord_5      = signed'(out_reg.coords[5]);
    assign coord_6      = signed'(out_reg.coords[6]);
    assign coord_7      = signed'(out_reg.coords[7]);
    assign last_point   = out_reg.last_point;
    assign bad_input    = out_reg.bad_input;

    // a bad run is a single transaction at point 0
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_input) |-> (last_point && (point_index == '0)))
        else $error("bad result not a lone point 0");

    // the mean point of a good run is never the last one
    a_mean_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_input && (point_index == '0)) |-> !last_point)
        else $error("mean point flagged last");

    // a stalled result stays put
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(point_index)
            && $stable(point_weight) && $stable(last_point)))
        else $error("stalled result changed");

endmodule
